// File: rtl/shortcut_modifier_token_parser_top_macros.svh
// Assertion macros shared by the modifier token parser RTL.
// SMTP_ASSERT expects clk and arst_n, SMTP_ASSERT_ALWAYS only clk, in the scope where it is used.
`ifndef SHORTCUT_MODIFIER_TOKEN_PARSER_TOP_MACROS_SVH
`define SHORTCUT_MODIFIER_TOKEN_PARSER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SMTP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SMTP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/smtp_pkg.sv
// Package for the shortcut modifier token parser: payload structs, codes,
// character constants and the decode result type. No dependencies.
`default_nettype none

package smtp_pkg;

	// Token characters
	localparam logic [7:0] CH_L = 8'h4C;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_W = 8'h57;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_LS = 8'h73; // s
	localparam logic [7:0] CH_LI = 8'h69; // i
	localparam logic [7:0] CH_LO = 8'h6F; // o
	localparam logic [7:0] CH_LP = 8'h70; // p
	localparam logic [7:0] CH_LR = 8'h72; // r
	localparam logic [7:0] CH_LT = 8'h74; // t
	localparam logic [7:0] CH_LH = 8'h68; // h

	// Left-side HID modifier bits
	localparam logic [3:0] MOD_CTRL  = 4'h1;
	localparam logic [3:0] MOD_SHIFT = 4'h2;
	localparam logic [3:0] MOD_ALT   = 4'h4;
	localparam logic [3:0] MOD_GUI   = 4'h8;

	// Sub-action codes
	localparam logic [1:0] SUB_PRESS   = 2'd0;
	localparam logic [1:0] SUB_RELEASE = 2'd1;
	localparam logic [1:0] SUB_TAP     = 2'd2;
	localparam logic [1:0] SUB_HOLD    = 2'd3;

	// Macro target status
	localparam logic [1:0] MS_WRITTEN = 2'd0;
	localparam logic [1:0] MS_REFUSED = 2'd1;
	localparam logic [1:0] MS_NONE    = 2'd2;

	// Key target status
	localparam logic [1:0] KS_WRITTEN     = 2'd0;
	localparam logic [1:0] KS_UNSUPPORTED = 2'd1;
	localparam logic [1:0] KS_REFUSED     = 2'd2;
	localparam logic [1:0] KS_NONE        = 2'd3;

	typedef enum logic [1:0] {
		SEL_OUTPUT = 2'd0,
		SEL_STICKY = 2'd1,
		SEL_INPUT  = 2'd2
	} sel_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       char_valid;
		logic       last;
		logic       macro_wanted;
		logic       key_wanted;
		logic       macro_is_keystroke;
		logic       key_is_keystroke;
		logic [1:0] start_sub_action;
	} token_item_t;

	typedef struct packed {
		logic       success;
		logic [7:0] input_mods;
		logic [7:0] output_mods;
		logic [7:0] sticky_mods;
		logic [1:0] sub_action;
		logic [1:0] macro_status;
		logic [7:0] key_modifiers;
		logic [1:0] key_status;
	} result_item_t;

	// Character class from the decoder
	typedef struct packed {
		logic       is_side;
		logic       side_left;
		logic       is_mod;
		logic [3:0] mod_bit;
		logic       is_sel;
		sel_t       sel;
		logic       is_sub;
		logic [1:0] sub;
	} char_class_t;

endpackage

`default_nettype wire

// File: rtl/shortcut_modifier_token_parser_top.sv
// Top level of the shortcut modifier token parser: input register, token
// parser and result register. Depends on smtp_pkg, smtp_parse, smtp_decode
// and the assertion macro header.
//
// Usage: token_item carries one character of a modifier token per transfer
// on the token channel (token_valid / token_ready). Mark the final character
// with last; a transfer with char_valid low and last high ends the token
// with no character of its own, one with both low is ignored. Each token
// yields exactly one transfer on the result channel (result_valid /
// result_ready) with the masks, sub-action and target statuses.
// Order: a character is held in the input register and parsed there; the
// result register is loaded as a last character moves on, so a result is
// offered once its last character leaves the input register.
// Throughput: one character per cycle while no last character is stalled.
// The parse of a character needs the token state left by the previous one.
// Stall: when the result is not taken, a further last character waits in the
// input register; characters that end no token keep flowing.
// Reset: arst_n clears both registers' valid flags and returns the token
// state to its start (left side, output mask, masks clear).
`default_nettype none
`include "shortcut_modifier_token_parser_top_macros.svh"

module shortcut_modifier_token_parser_top (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    token_valid,
	output logic                         token_ready,
	input  wire smtp_pkg::token_item_t   token_item,
	output logic                         result_valid,
	input  wire logic                    result_ready,
	output smtp_pkg::result_item_t       result_item
);

	logic                   valid_s1;
	smtp_pkg::token_item_t  item_s1;
	logic                   advance;
	logic                   step;
	smtp_pkg::result_item_t result_next;

	// Move the registered character on unless it ends a token and the result is stalled
	assign advance = valid_s1 && (!item_s1.last || !result_valid || result_ready);
	assign token_ready = !valid_s1 || advance;
	assign step = advance && (item_s1.char_valid || item_s1.last);

	// Input register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (token_ready) begin
			valid_s1 <= token_valid;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (token_valid && token_ready) begin
			item_s1 <= token_item;
		end
	end

	smtp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.result (result_next)
	);

	// Result register: valid flag, hold until transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && item_s1.last) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (advance && item_s1.last) begin
			result_item <= result_next;
		end
	end

	// Characters that end no token never wait
	`SMTP_ASSERT(a_mid_token_flows, valid_s1 && !item_s1.last |-> advance,
		"mid-token character stalled")
	// A token end always produces a pending result
	`SMTP_ASSERT(a_end_gives_result, advance && item_s1.last |=> result_valid,
		"token end did not load a result")
	// Written statuses only come from a successful parse
	`SMTP_ASSERT(a_status_needs_success,
		result_valid && (result_item.key_status == smtp_pkg::KS_WRITTEN
		|| result_item.macro_status == smtp_pkg::MS_WRITTEN) |-> result_item.success,
		"written status on a failed token")

endmodule

`default_nettype wire

// File: rtl/smtp_decode.sv
// Character decoder: classifies one token byte into side, modifier,
// mask-select or sub-action letters. Depends on smtp_pkg.
`default_nettype none

module smtp_decode (
	input  wire logic [7:0]          ch,
	output smtp_pkg::char_class_t    cls
);

	// Classify the byte; anything not listed leaves every class flag low
	always_comb begin
		cls = '0;
		cls.sel = smtp_pkg::SEL_OUTPUT;
		unique case (ch)
			smtp_pkg::CH_L: begin
				cls.is_side = 1'b1;
				cls.side_left = 1'b1;
			end
			smtp_pkg::CH_R: begin
				cls.is_side = 1'b1;
			end
			smtp_pkg::CH_S: begin
				cls.is_mod = 1'b1;
				cls.mod_bit = smtp_pkg::MOD_SHIFT;
			end
			smtp_pkg::CH_C: begin
				cls.is_mod = 1'b1;
				cls.mod_bit = smtp_pkg::MOD_CTRL;
			end
			smtp_pkg::CH_A: begin
				cls.is_mod = 1'b1;
				cls.mod_bit = smtp_pkg::MOD_ALT;
			end
			smtp_pkg::CH_W, smtp_pkg::CH_G: begin
				cls.is_mod = 1'b1;
				cls.mod_bit = smtp_pkg::MOD_GUI;
			end
			smtp_pkg::CH_LS: begin
				cls.is_sel = 1'b1;
				cls.sel = smtp_pkg::SEL_STICKY;
			end
			smtp_pkg::CH_LI: begin
				cls.is_sel = 1'b1;
				cls.sel = smtp_pkg::SEL_INPUT;
			end
			smtp_pkg::CH_LO: begin
				cls.is_sel = 1'b1;
				cls.sel = smtp_pkg::SEL_OUTPUT;
			end
			smtp_pkg::CH_LP: begin
				cls.is_sub = 1'b1;
				cls.sub = smtp_pkg::SUB_PRESS;
			end
			smtp_pkg::CH_LR: begin
				cls.is_sub = 1'b1;
				cls.sub = smtp_pkg::SUB_RELEASE;
			end
			smtp_pkg::CH_LT: begin
				cls.is_sub = 1'b1;
				cls.sub = smtp_pkg::SUB_TAP;
			end
			smtp_pkg::CH_LH: begin
				cls.is_sub = 1'b1;
				cls.sub = smtp_pkg::SUB_HOLD;
			end
			default: begin
				cls.is_side = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/smtp_parse.sv
// Token state and result logic: holds the masks, side, selection and
// sub-action across a token and forms the result on its last character.
// Depends on smtp_pkg, smtp_decode and the assertion macro header.
`default_nettype none
`include "shortcut_modifier_token_parser_top_macros.svh"

module smtp_parse (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    step,
	input  wire smtp_pkg::token_item_t   item,
	output smtp_pkg::result_item_t       result
);

	smtp_pkg::char_class_t cls;
	smtp_pkg::sel_t        sel_q, sel_n;
	logic                  left_q, left_n;
	logic [7:0]            in_mask_q, in_mask_n;
	logic [7:0]            out_mask_q, out_mask_n;
	logic [7:0]            stick_mask_q, stick_mask_n;
	logic [1:0]            held_q, held_n;
	logic                  type_exp_q, type_exp_n;
	logic                  sub_exp_q, sub_exp_n;
	logic                  all_ok_q, all_ok_n;
	logic                  at_start_q;
	logic [7:0]            mod_bits;
	logic [7:0]            joint;

	smtp_decode u_decode (
		.ch  (item.ch),
		.cls (cls)
	);

	// Apply one character to the token state
	always_comb begin
		mod_bits = left_q ? {4'b0000, cls.mod_bit} : {cls.mod_bit, 4'b0000};
		left_n = left_q;
		sel_n = sel_q;
		in_mask_n = in_mask_q;
		out_mask_n = out_mask_q;
		stick_mask_n = stick_mask_q;
		type_exp_n = type_exp_q;
		sub_exp_n = sub_exp_q;
		all_ok_n = all_ok_q;
		if (at_start_q) begin
			held_n = item.macro_wanted ? item.start_sub_action : smtp_pkg::SUB_PRESS;
		end else begin
			held_n = held_q;
		end
		if (item.char_valid) begin
			if (cls.is_side) begin
				left_n = cls.side_left;
			end else if (cls.is_mod) begin
				unique case (sel_q)
					smtp_pkg::SEL_STICKY: stick_mask_n = stick_mask_q | mod_bits;
					smtp_pkg::SEL_INPUT:  in_mask_n = in_mask_q | mod_bits;
					default:              out_mask_n = out_mask_q | mod_bits;
				endcase
				left_n = 1'b1;
			end else if (cls.is_sel) begin
				sel_n = cls.sel;
				type_exp_n = 1'b1;
			end else if (cls.is_sub) begin
				held_n = cls.sub;
				sub_exp_n = 1'b1;
			end else begin
				all_ok_n = 1'b0;
			end
		end
	end

	// Form the result from the updated state
	always_comb begin
		joint = in_mask_n | out_mask_n | stick_mask_n;
		result.success = all_ok_n;
		result.input_mods = in_mask_n;
		result.output_mods = out_mask_n;
		result.sticky_mods = stick_mask_n;
		result.sub_action = held_n;
		result.key_modifiers = 8'h00;
		priority if (!all_ok_n || !item.macro_wanted) begin
			result.macro_status = smtp_pkg::MS_NONE;
		end else if (!item.macro_is_keystroke && in_mask_n != 8'h00) begin
			result.macro_status = smtp_pkg::MS_REFUSED;
		end else begin
			result.macro_status = smtp_pkg::MS_WRITTEN;
		end
		priority if (!all_ok_n || !item.key_wanted) begin
			result.key_status = smtp_pkg::KS_NONE;
		end else if (type_exp_n || sub_exp_n) begin
			result.key_status = smtp_pkg::KS_UNSUPPORTED;
		end else if (!item.key_is_keystroke && joint != 8'h00) begin
			result.key_status = smtp_pkg::KS_REFUSED;
		end else begin
			result.key_status = smtp_pkg::KS_WRITTEN;
			result.key_modifiers = joint;
		end
	end

	// Advance the token state; drop back to the start state after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 1'b1;
			sel_q <= smtp_pkg::SEL_OUTPUT;
			in_mask_q <= 8'h00;
			out_mask_q <= 8'h00;
			stick_mask_q <= 8'h00;
			held_q <= smtp_pkg::SUB_PRESS;
			type_exp_q <= 1'b0;
			sub_exp_q <= 1'b0;
			all_ok_q <= 1'b1;
			at_start_q <= 1'b1;
		end else if (step) begin
			if (item.last) begin
				left_q <= 1'b1;
				sel_q <= smtp_pkg::SEL_OUTPUT;
				in_mask_q <= 8'h00;
				out_mask_q <= 8'h00;
				stick_mask_q <= 8'h00;
				held_q <= smtp_pkg::SUB_PRESS;
				type_exp_q <= 1'b0;
				sub_exp_q <= 1'b0;
				all_ok_q <= 1'b1;
				at_start_q <= 1'b1;
			end else begin
				left_q <= left_n;
				sel_q <= sel_n;
				in_mask_q <= in_mask_n;
				out_mask_q <= out_mask_n;
				stick_mask_q <= stick_mask_n;
				held_q <= held_n;
				type_exp_q <= type_exp_n;
				sub_exp_q <= sub_exp_n;
				all_ok_q <= all_ok_n;
				at_start_q <= 1'b0;
			end
		end
	end

	// A finished token leaves the parser at its start state
	`SMTP_ASSERT(a_token_end_restart, step && item.last |=> at_start_q && all_ok_q && left_q,
		"token state not restored after last character")
	// A token start always leaves the masks clear
	`SMTP_ASSERT(a_start_masks_clear,
		at_start_q |-> (in_mask_q == 8'h00 && out_mask_q == 8'h00 && stick_mask_q == 8'h00),
		"masks not clear at token start")

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking bench for shortcut_modifier_token_parser_top: directed and random tokens,
// a modifier token predictor with a scoreboard, and random stalls on both channels.
// Depends on smtp_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb;
	import smtp_pkg::*;

	// Target flags of one item: macro_wanted, key_wanted, macro/key keystroke
	localparam logic [3:0] F_MACRO = 4'b1000;
	localparam logic [3:0] F_KEY   = 4'b0100;
	localparam logic [3:0] F_MKEY  = 4'b0010;
	localparam logic [3:0] F_KKEY  = 4'b0001;
	localparam logic [3:0] F_NONE  = 4'b0000;

	localparam int ITEM_TARGET = 800;
	localparam int LONG_HOLD   = 300;

	// Predict parsed masks per token and check each result transfer in order
	class modifier_scoreboard;
		logic          left_side;
		sel_t          sel;
		logic [7:0]    in_m;
		logic [7:0]    out_m;
		logic [7:0]    st_m;
		logic [1:0]    sub;
		logic          type_x;
		logic          sub_x;
		logic          ok;
		logic          fresh;
		result_item_t  pending_results[$];
		int            fails;
		int            results_seen;

		function new();
			fails = 0;
			results_seen = 0;
			restart_token();
		endfunction

		function void restart_token();
			left_side = 1'b1;
			sel = SEL_OUTPUT;
			in_m = 8'h00;
			out_m = 8'h00;
			st_m = 8'h00;
			sub = SUB_PRESS;
			type_x = 1'b0;
			sub_x = 1'b0;
			ok = 1'b1;
			fresh = 1'b1;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// Advance the token state by one accepted item; queue a result on last
		function void note_token_item(token_item_t it);
			logic [3:0]   mb;
			logic [7:0]   bitv;
			logic [7:0]   joint;
			result_item_t r;
			if (!it.char_valid && !it.last)
				return;
			if (fresh) begin
				sub = it.macro_wanted ? it.start_sub_action : SUB_PRESS;
				fresh = 1'b0;
			end
			if (it.char_valid) begin
				mb = 4'h0;
				case (it.ch)
					CH_L: left_side = 1'b1;
					CH_R: left_side = 1'b0;
					CH_S: mb = MOD_SHIFT;
					CH_C: mb = MOD_CTRL;
					CH_A: mb = MOD_ALT;
					CH_W, CH_G: mb = MOD_GUI;
					CH_LS: begin sel = SEL_STICKY; type_x = 1'b1; end
					CH_LI: begin sel = SEL_INPUT; type_x = 1'b1; end
					CH_LO: begin sel = SEL_OUTPUT; type_x = 1'b1; end
					CH_LP: begin sub = SUB_PRESS; sub_x = 1'b1; end
					CH_LR: begin sub = SUB_RELEASE; sub_x = 1'b1; end
					CH_LT: begin sub = SUB_TAP; sub_x = 1'b1; end
					CH_LH: begin sub = SUB_HOLD; sub_x = 1'b1; end
					default: ok = 1'b0;
				endcase
				// Set the modifier in the selected mask, then fall back to left
				if (mb != 4'h0) begin
					bitv = left_side ? {4'h0, mb} : {mb, 4'h0};
					case (sel)
						SEL_STICKY: st_m = st_m | bitv;
						SEL_INPUT:  in_m = in_m | bitv;
						default:    out_m = out_m | bitv;
					endcase
					left_side = 1'b1;
				end
			end
			if (!it.last)
				return;

			joint = in_m | out_m | st_m;
			r.success = ok;
			r.input_mods = in_m;
			r.output_mods = out_m;
			r.sticky_mods = st_m;
			r.sub_action = sub;
			if (!ok || !it.macro_wanted)
				r.macro_status = MS_NONE;
			else if (!it.macro_is_keystroke && in_m != 8'h00)
				r.macro_status = MS_REFUSED;
			else
				r.macro_status = MS_WRITTEN;
			r.key_modifiers = 8'h00;
			if (!ok || !it.key_wanted)
				r.key_status = KS_NONE;
			else if (type_x || sub_x)
				r.key_status = KS_UNSUPPORTED;
			else if (!it.key_is_keystroke && joint != 8'h00)
				r.key_status = KS_REFUSED;
			else begin
				r.key_status = KS_WRITTEN;
				r.key_modifiers = joint;
			end
			pending_results.push_back(r);
			restart_token();
		endfunction

		task report(string msg);
			$display("MISMATCH at result %0d: %s", results_seen, msg);
			fails++;
		endtask

		task cmp(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("%s got 0x%02h want 0x%02h", name, got, want));
		endtask

		// Compare one result transfer with the oldest prediction
		task check_result(result_item_t got);
			result_item_t want;
			if (pending_results.size() == 0) begin
				report("result with no prediction pending");
				results_seen++;
				return;
			end
			want = pending_results.pop_front();
			cmp("success", got.success, want.success);
			cmp("input_mods", got.input_mods, want.input_mods);
			cmp("output_mods", got.output_mods, want.output_mods);
			cmp("sticky_mods", got.sticky_mods, want.sticky_mods);
			cmp("sub_action", got.sub_action, want.sub_action);
			cmp("macro_status", got.macro_status, want.macro_status);
			cmp("key_modifiers", got.key_modifiers, want.key_modifiers);
			cmp("key_status", got.key_status, want.key_status);
			results_seen++;
		endtask
	endclass

	logic          clk;
	logic          arst_n;
	logic          token_valid;
	logic          token_ready;
	token_item_t   token_item;
	logic          result_valid;
	logic          result_ready;
	result_item_t  result_item;

	modifier_scoreboard sb = new();

	bit no_idle = 1'b0;
	bit long_hold_req = 1'b0;
	int items_sent = 0;

	string plain_chars = "LRSCAWG";
	string mixed_chars = "LRSCAWGsioprth";

	shortcut_modifier_token_parser_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.token_valid  (token_valid),
		.token_ready  (token_ready),
		.token_item   (token_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic token_item_t mk_item(logic [7:0] c, logic cv, logic lst,
			logic [3:0] flags, logic [1:0] start);
		token_item_t t;
		t.ch = c;
		t.char_valid = cv;
		t.last = lst;
		{t.macro_wanted, t.key_wanted, t.macro_is_keystroke, t.key_is_keystroke} = flags;
		t.start_sub_action = start;
		return t;
	endfunction

	function automatic token_item_t rand_item(logic [7:0] c, logic cv, logic lst);
		logic [3:0] flags;
		logic [1:0] start;
		flags = 4'($urandom_range(0, 15));
		start = 2'($urandom_range(0, 3));
		return mk_item(c, cv, lst, flags, start);
	endfunction

	// Offer one item, with an occasional idle burst ahead of it; hold until transfer
	task automatic send_item(token_item_t it);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			token_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		token_valid <= 1'b1;
		token_item <= it;
		do @(posedge clk); while (token_ready !== 1'b1);
		sb.note_token_item(it);
		if (it.char_valid || it.last)
			items_sent++;
	endtask

	task automatic send_word(string s, logic [3:0] flags, logic [1:0] start);
		for (int i = 0; i < s.len(); i++)
			send_item(mk_item(s[i], 1'b1, i == s.len() - 1, flags, start));
	endtask

	// Mostly well-formed tokens; some carry a stray byte, stray idle items or an empty end
	task automatic send_random_token();
		int n;
		int kind;
		int bad_at;
		logic [7:0] c;
		kind = $urandom_range(0, 9);
		n = $urandom_range(1, 6);
		bad_at = (kind == 8) ? $urandom_range(0, n - 1) : -1;
		if (kind == 9 && $urandom_range(0, 1) == 1)
			n = 0;
		for (int i = 0; i < n; i++) begin
			if (i == bad_at)
				c = 8'($urandom_range(0, 255));
			else if (kind < 5)
				c = plain_chars[$urandom_range(0, plain_chars.len() - 1)];
			else
				c = mixed_chars[$urandom_range(0, mixed_chars.len() - 1)];
			if ($urandom_range(0, 9) == 0)
				send_item(rand_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
			send_item(rand_item(c, 1'b1, (i == n - 1) && kind != 9));
		end
		if (kind == 9)
			send_item(rand_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
	endtask

	// Result side: check every transfer, stall in bursts, honor a long hold-off
	initial begin
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid === 1'b1 && result_ready === 1'b1)
				sb.check_result(result_item);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 8) - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		bit hold_done;
		bit drain_done;
		hold_done = 1'b0;
		drain_done = 1'b0;
		arst_n <= 1'b0;
		token_valid <= 1'b0;
		token_item <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle item, empty token, every letter, failures on extreme bytes
		send_item(mk_item(8'h00, 1'b0, 1'b0, F_MACRO | F_KEY, SUB_HOLD));
		send_item(mk_item(8'hFF, 1'b0, 1'b1, F_MACRO | F_KEY, SUB_HOLD));
		send_word("RCSRAW", F_KEY | F_KKEY, SUB_TAP);
		send_word("iLG", F_MACRO | F_KEY, SUB_RELEASE);
		send_word("sAprth", F_MACRO | F_MKEY | F_KEY, SUB_PRESS);
		send_word("oRCp", F_MACRO | F_MKEY, SUB_TAP);
		send_word("S", F_KEY, SUB_HOLD);
		send_item(mk_item(8'hFF, 1'b1, 1'b1, F_MACRO | F_KEY | F_MKEY | F_KKEY, SUB_HOLD));
		send_item(mk_item(CH_C, 1'b1, 1'b0, F_NONE, SUB_RELEASE));
		send_item(mk_item(8'h00, 1'b1, 1'b1, F_MACRO | F_KEY | F_MKEY | F_KKEY, SUB_TAP));

		// Random tokens with one long result hold-off, one full drain, then no idling
		while (items_sent < ITEM_TARGET) begin
			if (!hold_done && items_sent >= ITEM_TARGET / 4) begin
				long_hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!drain_done && items_sent >= ITEM_TARGET / 2) begin
				token_valid <= 1'b0;
				do @(posedge clk); while (sb.pending() != 0);
				drain_done = 1'b1;
			end
			if (items_sent >= ITEM_TARGET * 4 / 5)
				no_idle = 1'b1;
			send_random_token();
		end

		token_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Stop a hung run
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
